FILE: rtl/complex_arithmetic_unit_defines.svh
// Assertion macros for the complex arithmetic unit.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT(lbl, clk, rstn, prop, msg)
`define CAU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_SCALE = 3'd3,
        OP_DIV   = 3'd4,
        OP_CONJ  = 3'd5,
        OP_MOD   = 3'd6,
        OP_NONE  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    // one queued word, already classified by the front end
    typedef struct packed {
        t_op                       op;
        logic                      dz;
        logic signed [DATA_W-1:0]  a_re;
        logic signed [DATA_W-1:0]  a_im;
        logic signed [DATA_W-1:0]  b_re;
        logic signed [DATA_W-1:0]  b_im;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

FILE: rtl/cau_front.sv
// Front end: takes command words, flags divide by zero, hands them to the queue.
// Depends on cau_pkg.
module cau_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [2:0]                  i_opcode,
    input  logic signed [31:0]          i_a_real,
    input  logic signed [31:0]          i_a_imag,
    input  logic signed [31:0]          i_b_real,
    input  logic signed [31:0]          i_b_imag,
    input  cau_pkg::t_fifo_stat         i_fstat,
    output logic                        busy,
    output logic                        o_push,
    output cau_pkg::t_item              o_item
);
    import cau_pkg::*;

    logic  r_v;
    t_item r_item;
    logic  w_take;

    assign busy   = r_v && i_fstat.full;
    assign o_push = r_v && !i_fstat.full;
    assign o_item = r_item;
    assign w_take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_take) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
        if (w_take) begin
            r_item.op   <= t_op'(i_opcode);
            r_item.dz   <= (i_b_real == '0) && (i_b_imag == '0);
            r_item.a_re <= i_a_real;
            r_item.a_im <= i_a_imag;
            r_item.b_re <= i_b_real;
            r_item.b_im <= i_b_imag;
        end
    end

endmodule

FILE: rtl/cau_fifo.sv
// Short queue between front and back ends.
// Depends on cau_pkg and complex_arithmetic_unit_defines.svh.
`include "complex_arithmetic_unit_defines.svh"
module cau_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cau_pkg::t_item      i_item,
    input  logic                i_pop,
    output cau_pkg::t_item      o_item,
    output cau_pkg::t_fifo_stat o_stat
);
    import cau_pkg::*;

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_item       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    `CAU_ASSERT(a_no_push_full, i_clk, i_rst_n, o_stat.full |-> !i_push, "push into full queue")
    `CAU_ASSERT(a_no_pop_empty, i_clk, i_rst_n, o_stat.empty |-> !i_pop, "pop from empty queue")
    `CAU_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= CNT_W'(FIFO_DEPTH), "queue count overrun")

endmodule

FILE: rtl/cau_back.sv
// Back end: multiply stage, combine stage, shared iterative divide/square-root unit.
// Depends on cau_pkg and complex_arithmetic_unit_defines.svh.
`include "complex_arithmetic_unit_defines.svh"
module cau_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cau_pkg::t_item      i_item,
    input  cau_pkg::t_fifo_stat i_fstat,
    output logic                o_pop,
    output logic                o_done,
    output logic signed [31:0]  o_res_real,
    output logic signed [31:0]  o_res_imag,
    output logic [1:0]          o_status
);
    import cau_pkg::*;

    localparam int PW    = 2 * DATA_W;         // product width
    localparam int SW    = PW + 1;             // sum of two products
    localparam int SH    = DATA_W + 1 - FRAC_BITS;
    localparam int LO_W  = DATA_W + 1;         // quotient bits
    localparam int RW    = DATA_W + 2;         // sqrt remainder
    localparam int ITW   = $clog2(LO_W);
    localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {CLS_SIMPLE, CLS_DIV, CLS_SQRT} t_cls;
    typedef enum logic [1:0] {IS_IDLE, IS_CHK, IS_RUN, IS_FIN} t_ist;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } t_sat;

    function automatic t_sat sat_add(input logic signed [DATA_W:0] v);
        t_sat s;
        s.ovf = 1'b0;
        s.val = v[DATA_W-1:0];
        if (v[DATA_W] != v[DATA_W-1]) begin
            s.ovf = 1'b1;
            s.val = v[DATA_W] ? SMIN : SMAX;
        end
        return s;
    endfunction

    // floor to FRAC_BITS fraction bits, then clamp
    function automatic t_sat sat_floor(input logic signed [SW-1:0] v);
        t_sat s;
        logic signed [SW-1:0] sh;
        logic                 hi_ok;
        sh    = v >>> FRAC_BITS;
        hi_ok = (sh[SW-1:DATA_W-1] == '0) || (sh[SW-1:DATA_W-1] == '1);
        s.ovf = !hi_ok;
        s.val = hi_ok ? sh[DATA_W-1:0] : (sh[SW-1] ? SMIN : SMAX);
        return s;
    endfunction

    // quotient magnitude to signed word
    function automatic t_sat div_fin(input logic big, input logic neg,
                                     input logic [LO_W-1:0] q, input logic rnz);
        t_sat s;
        logic [LO_W:0] qc;
        qc    = {1'b0, q} + (LO_W+1)'(neg && rnz);
        s.ovf = 1'b0;
        if (big) begin
            s.ovf = 1'b1;
            s.val = neg ? SMIN : SMAX;
        end else if (neg) begin
            if (qc > (LO_W+1)'(SMIN)) begin
                s.ovf = 1'b1;
                s.val = SMIN;
            end else begin
                s.val = DATA_W'(0) - qc[DATA_W-1:0];
            end
        end else if (qc > (LO_W+1)'(SMAX)) begin
            s.ovf = 1'b1;
            s.val = SMAX;
        end else begin
            s.val = qc[DATA_W-1:0];
        end
        return s;
    endfunction

    // ---------------- multiply stage
    logic                     w_adv;
    logic                     r1_v, r1_dz;
    t_op                      r1_op;
    logic signed [DATA_W-1:0] r1_ar, r1_ai;
    logic signed [DATA_W:0]   r1_sre, r1_sim;
    logic signed [PW-1:0]     r1_p0, r1_p1, r1_p2, r1_p3;
    logic [PW-1:0]            r1_p4, r1_p5;

    logic signed [DATA_W-1:0] w_x4, w_x5;
    logic                     w_is_mod;

    assign w_is_mod = (i_item.op == OP_MOD);
    assign w_x4     = w_is_mod ? i_item.a_re : i_item.b_re;
    assign w_x5     = w_is_mod ? i_item.a_im : i_item.b_im;
    assign o_pop    = w_adv && !i_fstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= !i_fstat.empty;
        end
        if (o_pop) begin
            r1_op  <= i_item.op;
            r1_dz  <= i_item.dz;
            r1_ar  <= i_item.a_re;
            r1_ai  <= i_item.a_im;
            r1_sre <= (i_item.op == OP_SUB)
                ? (DATA_W+1)'(i_item.a_re) - (DATA_W+1)'(i_item.b_re)
                : (DATA_W+1)'(i_item.a_re) + (DATA_W+1)'(i_item.b_re);
            r1_sim <= (i_item.op == OP_SUB)
                ? (DATA_W+1)'(i_item.a_im) - (DATA_W+1)'(i_item.b_im)
                : (DATA_W+1)'(i_item.a_im) + (DATA_W+1)'(i_item.b_im);
            r1_p0  <= i_item.a_re * i_item.b_re;
            r1_p1  <= i_item.a_im * i_item.b_im;
            r1_p2  <= i_item.a_re * i_item.b_im;
            r1_p3  <= i_item.a_im * i_item.b_re;
            r1_p4  <= PW'(w_x4 * w_x4);
            r1_p5  <= PW'(w_x5 * w_x5);
        end
    end

    // ---------------- combine stage
    logic                     r2_v;
    t_cls                     r2_cls;
    logic [DATA_W-1:0]        r2_rr, r2_ri;
    t_status                  r2_st;
    logic signed [SW-1:0]     r2_n1, r2_n2;
    logic [PW-1:0]            r2_sq;

    t_cls                     n_cls;
    t_sat                     w_s1, w_s2;
    logic [DATA_W-1:0]        n_rr, n_ri;
    t_status                  n_st;
    logic signed [SW-1:0]     w_ext0, w_ext1, w_ext2, w_ext3;

    assign w_ext0 = SW'(r1_p0);
    assign w_ext1 = SW'(r1_p1);
    assign w_ext2 = SW'(r1_p2);
    assign w_ext3 = SW'(r1_p3);

    always_comb begin
        n_cls = CLS_SIMPLE;
        w_s1  = '0;
        w_s2  = '0;
        case (r1_op)
            OP_ADD, OP_SUB: begin
                w_s1 = sat_add(r1_sre);
                w_s2 = sat_add(r1_sim);
            end
            OP_MUL: begin
                w_s1 = sat_floor(w_ext0 - w_ext1);
                w_s2 = sat_floor(w_ext2 + w_ext3);
            end
            OP_SCALE: begin
                w_s1 = sat_floor(w_ext0);
                w_s2 = sat_floor(w_ext3);
            end
            OP_DIV: begin
                if (r1_dz) begin
                    w_s1.val = r1_ar[DATA_W-1] ? SMIN : SMAX;
                    w_s2.val = r1_ai[DATA_W-1] ? SMIN : SMAX;
                end else begin
                    n_cls = CLS_DIV;
                end
            end
            OP_CONJ: begin
                w_s1.val = r1_ar;
                w_s2     = sat_add((DATA_W+1)'(0) - (DATA_W+1)'(r1_ai));
            end
            OP_MOD:  n_cls = CLS_SQRT;
            default: ;
        endcase
        n_rr = w_s1.val;
        n_ri = w_s2.val;
        if (r1_op == OP_DIV && r1_dz) begin
            n_st = ST_DIVZ;
        end else if (w_s1.ovf || w_s2.ovf) begin
            n_st = ST_OVF;
        end else begin
            n_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
        if (w_adv) begin
            r2_cls <= n_cls;
            r2_rr  <= n_rr;
            r2_ri  <= n_ri;
            r2_st  <= n_st;
            r2_n1  <= w_ext0 + w_ext1;
            r2_n2  <= w_ext3 - w_ext2;
            r2_sq  <= r1_p4 + r1_p5;
        end
    end

    // ---------------- iterative unit and output register
    t_ist              r_st;
    logic              r_sqrt;
    logic [ITW-1:0]    r_it;
    logic              r_neg1, r_neg2, r_big1, r_big2;
    logic [PW-1:0]     r_mag1, r_mag2, r_den;
    logic [PW-1:0]     r_rem1, r_rem2;
    logic [LO_W-1:0]   r_lo1, r_lo2, r_q1, r_q2;
    logic [PW-1:0]     r_rad;
    logic [RW-1:0]     r_srem;
    logic [DATA_W-1:0] r_root;
    logic              r_done;
    logic [DATA_W-1:0] r_rr, r_ri;
    t_status           r_ost;

    logic              w_launch;
    logic [PW:0]       w_t1, w_t2;
    logic              w_ge1, w_ge2;
    logic [RW+1:0]     w_sr, w_trial;
    logic              w_sge;
    t_sat              w_d1, w_d2;

    assign w_adv    = (r_st == IS_IDLE);
    assign w_launch = w_adv && r2_v && (r2_cls != CLS_SIMPLE);

    assign w_t1    = {r_rem1, r_lo1[LO_W-1]};
    assign w_t2    = {r_rem2, r_lo2[LO_W-1]};
    assign w_ge1   = w_t1 >= {1'b0, r_den};
    assign w_ge2   = w_t2 >= {1'b0, r_den};
    assign w_sr    = {r_srem, r_rad[PW-1:PW-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sge   = w_sr >= w_trial;
    assign w_d1    = div_fin(r_big1, r_neg1, r_q1, r_rem1 != '0);
    assign w_d2    = div_fin(r_big2, r_neg2, r_q2, r_rem2 != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= IS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                IS_IDLE: begin
                    if (w_launch) begin
                        r_sqrt <= (r2_cls == CLS_SQRT);
                        r_neg1 <= r2_n1[SW-1];
                        r_neg2 <= r2_n2[SW-1];
                        r_mag1 <= r2_n1[SW-1] ? PW'(-r2_n1) : PW'(r2_n1);
                        r_mag2 <= r2_n2[SW-1] ? PW'(-r2_n2) : PW'(r2_n2);
                        r_den  <= r2_sq;
                        r_rad  <= r2_sq;
                        r_srem <= '0;
                        r_root <= '0;
                        r_it   <= ITW'(DATA_W - 1);
                        r_st   <= (r2_cls == CLS_SQRT) ? IS_RUN : IS_CHK;
                    end else if (r2_v) begin
                        r_done <= 1'b1;
                        r_rr   <= r2_rr;
                        r_ri   <= r2_ri;
                        r_ost  <= r2_st;
                    end
                end
                IS_CHK: begin
                    // quotient of 2^(DATA_W+1) or more saturates either way
                    r_big1 <= (r_mag1 >> SH) >= r_den;
                    r_big2 <= (r_mag2 >> SH) >= r_den;
                    r_rem1 <= r_mag1 >> SH;
                    r_rem2 <= r_mag2 >> SH;
                    r_lo1  <= LO_W'(r_mag1 << FRAC_BITS);
                    r_lo2  <= LO_W'(r_mag2 << FRAC_BITS);
                    r_q1   <= '0;
                    r_q2   <= '0;
                    r_it   <= ITW'(LO_W - 1);
                    r_st   <= IS_RUN;
                end
                IS_RUN: begin
                    if (r_sqrt) begin
                        r_srem <= w_sge ? RW'(w_sr - w_trial) : RW'(w_sr);
                        r_root <= {r_root[DATA_W-2:0], w_sge};
                        r_rad  <= r_rad << 2;
                    end else begin
                        r_rem1 <= w_ge1 ? PW'(w_t1 - {1'b0, r_den}) : PW'(w_t1);
                        r_rem2 <= w_ge2 ? PW'(w_t2 - {1'b0, r_den}) : PW'(w_t2);
                        r_q1   <= {r_q1[LO_W-2:0], w_ge1};
                        r_q2   <= {r_q2[LO_W-2:0], w_ge2};
                        r_lo1  <= r_lo1 << 1;
                        r_lo2  <= r_lo2 << 1;
                    end
                    if (r_it == '0) begin
                        r_st <= IS_FIN;
                    end else begin
                        r_it <= r_it - 1'b1;
                    end
                end
                IS_FIN: begin
                    r_done <= 1'b1;
                    r_st   <= IS_IDLE;
                    if (r_sqrt) begin
                        r_rr  <= r_root[DATA_W-1] ? SMAX : r_root;
                        r_ri  <= '0;
                        r_ost <= r_root[DATA_W-1] ? ST_OVF : ST_OK;
                    end else begin
                        r_rr  <= w_d1.val;
                        r_ri  <= w_d2.val;
                        r_ost <= (w_d1.ovf || w_d2.ovf) ? ST_OVF : ST_OK;
                    end
                end
                default: r_st <= IS_IDLE;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_res_real = r_rr;
    assign o_res_imag = r_ri;
    assign o_status   = r_ost;

    `CAU_ASSERT(a_hold_while_iter, i_clk, i_rst_n, (r_st != IS_IDLE) |-> !o_pop, "pop while iterating")
    `CAU_ASSERT(a_launch_leaves_idle, i_clk, i_rst_n, w_launch |=> (r_st != IS_IDLE), "launch lost")
    `CAU_ASSERT(a_fin_gives_word, i_clk, i_rst_n, (r_st == IS_FIN) |=> r_done, "iterative result dropped")
    `CAU_ASSERT_ALWAYS(a_divz_saturated, i_clk,
        (r_done && r_ost == ST_DIVZ) |-> ((r_rr == SMAX || r_rr == SMIN) && (r_ri == SMAX || r_ri == SMIN)),
        "divide by zero not saturated")

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit on signed Q16.16 operands, top level.
// Depends on cau_pkg, cau_front, cau_fifo, cau_back.
//
//   channel   handshake            payload
//   command   start / busy         i_opcode, i_a_real, i_a_imag, i_b_real, i_b_imag
//   result    o_done (strobe)      o_res_real, o_res_imag, o_status
//
// Add, subtract, multiply, scale, conjugate and divide by zero pass through the back end
// stages without iterating and issue one word per cycle while no divide or modulus runs.
// Divide runs 33 quotient steps and modulus 32 root steps on one shared iterative
// unit, which holds the back end meanwhile.
// A four-word queue sits between front and back; busy rises when it and the front
// register are both full. Reset is synchronous and clears all control state.
// Results are strobed for one cycle and cannot be stalled.
module complex_arithmetic_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_imag,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_imag,
    output logic               o_done,
    output logic signed [31:0] o_res_real,
    output logic signed [31:0] o_res_imag,
    output logic [1:0]         o_status
);
    import cau_pkg::*;

    t_item      w_fin, w_fout;
    t_fifo_stat w_fstat;
    logic       w_push, w_pop;

    cau_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_a_real (i_a_real),
        .i_a_imag (i_a_imag),
        .i_b_real (i_b_real),
        .i_b_imag (i_b_imag),
        .i_fstat  (w_fstat),
        .busy     (busy),
        .o_push   (w_push),
        .o_item   (w_fin)
    );

    cau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fin),
        .i_pop   (w_pop),
        .o_item  (w_fout),
        .o_stat  (w_fstat)
    );

    cau_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (w_fout),
        .i_fstat    (w_fstat),
        .o_pop      (w_pop),
        .o_done     (o_done),
        .o_res_real (o_res_real),
        .o_res_imag (o_res_imag),
        .o_status   (o_status)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for complex_arithmetic_unit.
// Depends on cau_pkg and the RTL; the expected-result board predicts each command's word.
`timescale 1ns / 100ps

module tb_top;
    import cau_pkg::*;

    localparam int        WATCHDOG_LIMIT = 5000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  st;
    } cplx_word_t;

    class cplx_result_board;
        cplx_word_t pending[$];
        int         mismatches = 0;

        function logic [31:0] clamp(logic signed [99:0] v, inout bit ovf);
            if (v > $signed({68'd0, Q_MAX})) begin
                ovf = 1;
                return Q_MAX;
            end
            if (v < -$signed(100'sh8000_0000)) begin
                ovf = 1;
                return Q_MIN;
            end
            return v[31:0];
        endfunction

        // floor(num * 2^FRAC / den), den > 0
        function logic signed [99:0] floor_div(logic signed [99:0] num,
                                               logic signed [99:0] den);
            logic signed [99:0] mag, q, r;
            bit neg;
            neg = num < 0;
            mag = neg ? -num : num;
            mag = mag <<< FRAC_BITS;
            q = mag / den;
            r = mag % den;
            if (neg && r != 0) q = q + 1;
            return neg ? -q : q;
        endfunction

        function logic [31:0] root_floor(logic [63:0] s);
            logic [63:0] res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > s) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (s >= res + bitv) begin
                    s = s - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res[31:0];
        endfunction

        function void note_command(logic [2:0] op, logic signed [31:0] ar,
                                   logic signed [31:0] ai, logic signed [31:0] br,
                                   logic signed [31:0] bi);
            cplx_word_t w;
            bit ovf;
            logic signed [99:0] xar, xai, xbr, xbi, den, sq;
            logic [31:0] root;
            xar = ar; xai = ai; xbr = br; xbi = bi;
            ovf = 0;
            w.re = 0; w.im = 0; w.st = ST_OK;
            case (t_op'(op))
                OP_ADD: begin
                    w.re = clamp(xar + xbr, ovf);
                    w.im = clamp(xai + xbi, ovf);
                end
                OP_SUB: begin
                    w.re = clamp(xar - xbr, ovf);
                    w.im = clamp(xai - xbi, ovf);
                end
                OP_MUL: begin
                    w.re = clamp((xar * xbr - xai * xbi) >>> FRAC_BITS, ovf);
                    w.im = clamp((xar * xbi + xbr * xai) >>> FRAC_BITS, ovf);
                end
                OP_SCALE: begin
                    w.re = clamp((xar * xbr) >>> FRAC_BITS, ovf);
                    w.im = clamp((xai * xbr) >>> FRAC_BITS, ovf);
                end
                OP_DIV: begin
                    if (br == 0 && bi == 0) begin
                        w.st = ST_DIVZ;
                        w.re = ar < 0 ? Q_MIN : Q_MAX;
                        w.im = ai < 0 ? Q_MIN : Q_MAX;
                    end else begin
                        den = xbr * xbr + xbi * xbi;
                        w.re = clamp(floor_div(xar * xbr + xai * xbi, den), ovf);
                        w.im = clamp(floor_div(xai * xbr - xar * xbi, den), ovf);
                    end
                end
                OP_CONJ: begin
                    w.re = ar;
                    w.im = clamp(-xai, ovf);
                end
                OP_MOD: begin
                    sq = xar * xar + xai * xai;
                    root = root_floor(sq[63:0]);
                    w.re = clamp($signed({68'd0, root}), ovf);
                end
                default: ;
            endcase
            if (w.st == ST_OK && ovf) w.st = ST_OVF;
            pending.push_back(w);
        endfunction

        function void check_result(logic [31:0] re, logic [31:0] im, logic [1:0] st);
            cplx_word_t w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word re=%h im=%h st=%0d", re, im, st);
                return;
            end
            w = pending.pop_front();
            if (re !== w.re || im !== w.im || st !== w.st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                             w.re, w.im, w.st, re, im, st);
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [2:0]         i_opcode = '0;
    logic signed [31:0] i_a_real = '0;
    logic signed [31:0] i_a_imag = '0;
    logic signed [31:0] i_b_real = '0;
    logic signed [31:0] i_b_imag = '0;
    logic               o_done;
    logic signed [31:0] o_res_real;
    logic signed [31:0] o_res_imag;
    logic [1:0]         o_status;

    cplx_result_board board = new();
    int idle_cycles = 0;

    complex_arithmetic_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_a_real   (i_a_real),
        .i_a_imag   (i_a_imag),
        .i_b_real   (i_b_real),
        .i_b_imag   (i_b_imag),
        .o_done     (o_done),
        .o_res_real (o_res_real),
        .o_res_imag (o_res_imag),
        .o_status   (o_status)
    );

    always #5 i_clk = ~i_clk;

    // accept commands before results so a word issued in the same cycle as its command would still find its entry
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                board.note_command(i_opcode, i_a_real, i_a_imag, i_b_real, i_b_imag);
            if (o_done)
                board.check_result(o_res_real, o_res_imag, o_status);
            if ((start && !busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_cmd(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
                            logic [31:0] br, logic [31:0] bi);
        start    <= 1'b1;
        i_opcode <= op;
        i_a_real <= ar;
        i_a_imag <= ai;
        i_b_real <= br;
        i_b_imag <= bi;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_operand();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom();
            3:       return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            4:       return Q_MAX - $urandom_range(0, 3);
            5:       return Q_MIN + $urandom_range(0, 3);
            6:       return 32'd0;
            default: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom())};
        endcase
    endfunction

    initial begin
        int burst;
        logic [2:0] op;
        logic [31:0] br, bi;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, every opcode, special cases
        send_cmd(OP_ADD,   Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        send_cmd(OP_ADD,   32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000);
        send_cmd(OP_SUB,   Q_MIN, Q_MAX, 32'd1, 32'hFFFF_FFFF);
        send_cmd(OP_SUB,   32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
        send_cmd(OP_MUL,   Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_cmd(OP_MUL,   32'h0001_8000, 32'hFFFF_8000, 32'h0000_0003, 32'hFFFF_FFFD);
        send_cmd(OP_MUL,   Q_MAX, Q_MAX, Q_MAX, Q_MIN);
        send_cmd(OP_SCALE, Q_MIN, Q_MAX, Q_MIN, 32'h1234_5678);
        send_cmd(OP_SCALE, 32'hFFFF_FFFF, 32'd1, 32'h0000_8000, 32'd0);
        send_cmd(OP_DIV,   32'h0001_0000, 32'hFFFF_0000, 32'd0, 32'd0);
        send_cmd(OP_DIV,   32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        send_cmd(OP_DIV,   32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_cmd(OP_DIV,   Q_MAX, Q_MIN, 32'd1, 32'd0);
        send_cmd(OP_DIV,   Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_cmd(OP_DIV,   32'hFFFF_FFFF, 32'd1, Q_MAX, Q_MAX);
        send_cmd(OP_CONJ,  Q_MIN, Q_MIN, 32'd0, 32'd0);
        send_cmd(OP_CONJ,  Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_cmd(OP_MOD,   Q_MIN, Q_MIN, 32'd0, 32'd0);
        send_cmd(OP_MOD,   32'd0, 32'd0, Q_MAX, Q_MAX);
        send_cmd(OP_MOD,   32'h0003_0000, 32'hFFFC_0000, 32'd0, 32'd0);
        send_cmd(OP_NONE,  Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        drain();

        // random: bursts with gaps, bursts sometimes back to back
        for (int n = 0; n < 800; ) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst; k++) begin
                op = 3'($urandom_range(0, 7));
                br = rnd_operand();
                bi = rnd_operand();
                if (op == OP_DIV && $urandom_range(0, 5) == 0) begin
                    br = 0;
                    bi = 0;
                end
                send_cmd(op, rnd_operand(), rnd_operand(), br, bi);
            end
            n += burst;
            if (n >= 400 && n - burst < 400) drain();
            if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 20));
        end
        drain();
        repeat (60) @(negedge i_clk);

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
